// File: hw/rtl/sor_pkg.sv
// ----------------------------------------------------------------------------
// Silhouette outline filter package
// Shared types and register indexes for the outline filter and its line cells.
// ----------------------------------------------------------------------------
package sor_pkg;

   // Width of the configuration register index.
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH    = 3'd0,
      CSR_FRAME_HEIGHT   = 3'd1,
      CSR_EDGE_COLOR     = 3'd2,
      CSR_FILL_COLOR     = 3'd3,
      CSR_OUTLINE_ENABLE = 3'd4
   } sor_csr_type;

   // Kinds of input item.
   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_FLUSH = 1'b1
   } sor_req_kind_type;

   // One column of the two buffered rows: the row just above the incoming
   // one and the row above that.
   typedef struct packed {
      logic [7:0] middle;
      logic [7:0] upper;
   } sor_col_type;

endpackage

// File: hw/rtl/sor_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one pixel or flush item per transfer.
// ----------------------------------------------------------------------------
interface sor_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] pixel_in;

   modport source (output valid, output req_type, output pixel_in, input ready);
   modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// File: hw/rtl/sor_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one recolored pixel per transfer.
// ----------------------------------------------------------------------------
interface sor_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// File: hw/rtl/sor_cell.sv
// ----------------------------------------------------------------------------
// Line buffer cell
// Holds one column of the two buffered rows and passes it to the next cell
// on every shift; the entry cell loads the new column instead.
// ----------------------------------------------------------------------------
module sor_cell
   import sor_pkg::*;
(
   input  logic        clock,
   input  logic        shift_en,
   input  logic        is_entry,
   input  sor_col_type entry_in,
   input  sor_col_type prev_in,
   output sor_col_type col_out
);

   sor_col_type col_ff;
   sor_col_type col_in;

   // The entry cell starts the chain; every other cell takes its neighbor.
   assign col_in = is_entry ? entry_in : prev_in;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// File: hw/rtl/sor_line_chain.sv
// ----------------------------------------------------------------------------
// Line buffer chain
// A row of cells that forms a delay line one frame row long. New columns
// enter at the cell chosen by the row width and leave at the last cell.
// ----------------------------------------------------------------------------
module sor_line_chain
   import sor_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     shift_en,
   input  logic [$clog2(DEPTH)-1:0] entry_idx,
   input  sor_col_type              head_in,
   output sor_col_type              tail_out,
   output logic [7:0]               next_middle
);

   localparam int IdxW = $clog2(DEPTH);

   sor_col_type links [DEPTH];

   // Cell zero has no left neighbor, so it only ever loads the head column.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      sor_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .is_entry (entry_idx == IdxW'(k)),
         .entry_in (head_in),
         .prev_in  ((k == 0) ? head_in : links[(k == 0) ? 0 : k - 1]),
         .col_out  (links[k])
      );
   end

   // The last cell holds the current column, the one before it the next.
   assign tail_out    = links[DEPTH-1];
   assign next_middle = links[DEPTH-2].middle;

endmodule

// File: hw/rtl/silhouette_outline_filter.sv
// A pixel of row r has its result registered when the same column of row r+1
// is transferred; the last row drains on any later items. Throughput: one item
// per cycle while the output register is free or read; the chain shifts per
// pixel or drain item taken. Reset clears the counters, the output valid flag
// and config (width 8, height 8, colors 0, outline off), not the line buffer.
// ----------------------------------------------------------------------------
// Silhouette outline filter
// Four-neighbor outline of a byte image streamed in raster order, built on a
// line buffer made of a chain of column cells.
// ----------------------------------------------------------------------------
module silhouette_outline_filter
   import sor_pkg::*;
#(
   parameter int MAX_WIDTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   sor_req_if.sink              req_bus,
   sor_rsp_if.source            rsp_bus,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int CntW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
   localparam int IdxW = $clog2(MAX_WIDTH);

   // Configuration registers.
   logic [7:0] frame_width_ff;
   logic [7:0] frame_height_ff;
   logic [7:0] edge_color_ff;
   logic [7:0] fill_color_ff;
   logic       outline_enable_ff;

   // Position and frame state.
   logic [7:0] in_col_ff,  in_col_in;
   logic [7:0] in_row_ff,  in_row_in;
   logic [7:0] out_col_ff, out_col_in;
   logic       complete_ff, complete_in;
   logic [7:0] held_ff,    held_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_ff;
   logic       rsp_last_ff;

   logic              req_fire;
   logic              shift_en;
   logic              res_valid;
   logic [7:0]        res_pixel;
   logic              res_last;
   logic [7:0]        width_nz;
   logic [7:0]        height_nz;
   logic [CntW-1:0]   weff;
   logic [CntW-1:0]   heff;
   logic [CntW-1:0]   entry_idx;
   sor_col_type       head_col;
   sor_col_type       tail_col;
   logic [7:0]        next_middle;
   logic [CntW-1:0]   col_w;
   logic [CntW-1:0]   row_w;
   logic [CntW-1:0]   out_col_w;
   logic              interior;

   function automatic logic [7:0] recolor(input logic [7:0] v, input logic inner,
                                          input logic en, input logic [7:0] edge_c,
                                          input logic [7:0] fill_c);
      logic [7:0] r;
      if (!en) begin
         r = v;
      end else if (inner) begin
         r = fill_c;
      end else if (v != 8'd0) begin
         r = edge_c;
      end else begin
         r = 8'd0;
      end
      return r;
   endfunction

   // Effective frame size: zero counts as one, width is capped by the buffer.
   always_comb begin
      width_nz  = (frame_width_ff == 8'd0) ? 8'd1 : frame_width_ff;
      height_nz = (frame_height_ff == 8'd0) ? 8'd1 : frame_height_ff;
      weff      = (CntW'(width_nz) > CntW'(MAX_WIDTH)) ? CntW'(MAX_WIDTH) : CntW'(width_nz);
      heff      = CntW'(height_nz);
      entry_idx = CntW'(MAX_WIDTH) - weff;
   end

   // Line buffer: the middle row shifts down into the upper row.
   assign head_col.middle = req_bus.pixel_in;
   assign head_col.upper  = tail_col.middle;

   sor_line_chain #(
      .DEPTH (MAX_WIDTH)
   ) u_chain (
      .clock       (clock),
      .shift_en    (shift_en),
      .entry_idx   (entry_idx[IdxW-1:0]),
      .head_in     (head_col),
      .tail_out    (tail_col),
      .next_middle (next_middle)
   );

   // A new item is taken whenever the output register is free or draining.
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;

   assign col_w     = CntW'(in_col_ff);
   assign row_w     = CntW'(in_row_ff);
   assign out_col_w = CntW'(out_col_ff);

   // Interior test for the position one row above the incoming pixel.
   always_comb begin
      interior = 1'b0;
      if (row_w >= CntW'(2) && row_w + CntW'(1) <= heff &&
          col_w >= CntW'(1) && col_w + CntW'(2) <= weff) begin
         interior = (held_ff != 8'd0) && (next_middle != 8'd0) &&
                    (tail_col.upper != 8'd0) && (req_bus.pixel_in != 8'd0);
      end
   end

   // Per-item control: drain the last row, take a pixel into the window, or ignore a flush.
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      complete_in = complete_ff;
      held_in     = held_ff;
      shift_en    = 1'b0;
      res_valid   = 1'b0;
      res_pixel   = 8'd0;
      res_last    = 1'b0;
      if (req_fire) begin
         if (complete_ff) begin
            shift_en  = 1'b1;
            res_valid = 1'b1;
            res_pixel = recolor(tail_col.middle, 1'b0, outline_enable_ff,
                                edge_color_ff, fill_color_ff);
            res_last  = (out_col_w + CntW'(1) >= weff);
            if (res_last) begin
               in_col_in   = 8'd0;
               in_row_in   = 8'd0;
               out_col_in  = 8'd0;
               complete_in = 1'b0;
               held_in     = 8'd0;
            end else begin
               out_col_in = out_col_ff + 8'd1;
            end
         end else if (req_bus.req_type == REQ_PIXEL) begin
            shift_en = 1'b1;
            if (in_row_ff != 8'd0) begin
               res_valid = 1'b1;
               res_pixel = recolor(tail_col.middle, interior, outline_enable_ff,
                                   edge_color_ff, fill_color_ff);
               res_last  = (row_w >= heff) && (col_w + CntW'(1) >= weff);
            end
            held_in = tail_col.middle;
            if (col_w + CntW'(1) >= weff) begin
               in_col_in = 8'd0;
               held_in   = 8'd0;
               if (row_w + CntW'(1) >= heff) begin
                  complete_in = 1'b1;
                  out_col_in  = 8'd0;
                  in_row_in   = 8'd0;
               end else begin
                  in_row_in = in_row_ff + 8'd1;
               end
            end else begin
               in_col_in = in_col_ff + 8'd1;
            end
         end
      end
   end

   // The output register holds a result until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= 8'd0;
         in_row_ff    <= 8'd0;
         out_col_ff   <= 8'd0;
         complete_ff  <= 1'b0;
         held_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         complete_ff  <= complete_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_pixel_ff <= res_pixel;
         rsp_last_ff  <= res_last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_out  = rsp_pixel_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= 8'd8;
         frame_height_ff   <= 8'd8;
         edge_color_ff     <= 8'd0;
         fill_color_ff     <= 8'd0;
         outline_enable_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (sor_csr_type'(csr_index))
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata;
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            CSR_EDGE_COLOR:     edge_color_ff     <= csr_wdata;
            CSR_FILL_COLOR:     fill_color_ff     <= csr_wdata;
            CSR_OUTLINE_ENABLE: outline_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

endmodule

// File: dv/silhouette_outline_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Silhouette outline filter testbench
// Streams byte images through the filter under random flow control and checks
// every recolored pixel against a line-buffer predictor kept in step with each
// transfer. Frame sizes, colors and the outline switch change between phases,
// including size changes in the middle of a frame.
// ----------------------------------------------------------------------------
module silhouette_outline_filter_tb;
   import sor_pkg::*;

   localparam int LINE_DEPTH     = 256;
   localparam int CLOCK_PERIOD   = 10;
   localparam int ITEM_TARGET    = 1950;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 250;

   typedef struct {
      sor_req_kind_type kind;
      logic [7:0]       pixel;
   } stream_item_t;

   typedef struct {
      logic [7:0] pixel;
      logic       last;
   } outline_result_t;

   typedef enum logic [1:0] {
      RX_STREAM,
      RX_HALF,
      RX_SPARSE
   } rx_mode_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_wdata;

   sor_req_if req_if ();
   sor_rsp_if rsp_if ();

   silhouette_outline_filter #(
      .MAX_WIDTH (LINE_DEPTH)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_if),
      .rsp_bus      (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Pending input items and the recolored pixels still owed by the filter.
   stream_item_t    send_q[$];
   outline_result_t expected_pixels[$];
   int              mismatch_count = 0;

   // Shadow copy of the configuration registers.
   logic [7:0] cfg_width   = 8'd8;
   logic [7:0] cfg_height  = 8'd8;
   logic [7:0] cfg_edge    = 8'd0;
   logic [7:0] cfg_fill    = 8'd0;
   logic       cfg_outline = 1'b0;

   // Predictor state: the two buffered rows and the raster counters.
   logic [7:0]  line_upper  [LINE_DEPTH];
   logic [7:0]  line_middle [LINE_DEPTH];
   int unsigned pred_in_col     = 0;
   int unsigned pred_in_row     = 0;
   int unsigned pred_drain_col  = 0;
   bit          frame_in_done   = 1'b0;
   logic [7:0]  left_byte       = 8'd0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned active_width();
      int unsigned w;
      w = (cfg_width == 0) ? 1 : cfg_width;
      return (w > LINE_DEPTH) ? LINE_DEPTH : w;
   endfunction

   function automatic int unsigned active_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic logic [7:0] paint_pixel(logic [7:0] v, bit interior);
      if (!cfg_outline)
         return v;
      if (interior)
         return cfg_fill;
      return (v != 0) ? cfg_edge : 8'h00;
   endfunction

   // Advance the predictor by one accepted item and queue the pixel it owes.
   function automatic void predict_outline(sor_req_kind_type kind, logic [7:0] px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     c;
      int unsigned     r;
      int unsigned     orow;
      logic [7:0]      mid_here;
      bit              interior;
      outline_result_t res;
      w = active_width();
      h = active_height();

      // The last row drains on any item once the frame's pixels are all in.
      if (frame_in_done) begin
         c = pred_drain_col;
         res.pixel = paint_pixel(line_middle[c], 1'b0);
         res.last  = (c + 1 >= w);
         expected_pixels.push_back(res);
         if (res.last) begin
            pred_in_col    = 0;
            pred_in_row    = 0;
            pred_drain_col = 0;
            frame_in_done  = 1'b0;
            left_byte      = 8'd0;
         end else begin
            pred_drain_col = c + 1;
         end
         return;
      end

      if (kind == REQ_FLUSH)
         return;

      c = pred_in_col;
      r = pred_in_row;
      mid_here = line_middle[c];

      // A pixel below row zero releases the pixel above it.
      if (r >= 1) begin
         orow = r - 1;
         interior = 1'b0;
         if (orow >= 1 && orow + 2 <= h && c >= 1 && c + 2 <= w)
            interior = (left_byte != 0) && (line_middle[c + 1] != 0) &&
                       (line_upper[c] != 0) && (px != 0);
         res.pixel = paint_pixel(mid_here, interior);
         res.last  = (orow + 1 >= h) && (c + 1 >= w);
         expected_pixels.push_back(res);
      end

      line_upper[c]  = mid_here;
      line_middle[c] = px;
      left_byte      = mid_here;

      // Step the raster position; the frame's last pixel starts the drain.
      if (c + 1 >= w) begin
         pred_in_col = 0;
         left_byte   = 8'd0;
         if (r + 1 >= h) begin
            frame_in_done  = 1'b1;
            pred_drain_col = 0;
            pred_in_row    = 0;
         end else begin
            pred_in_row = r + 1;
         end
      end else begin
         pred_in_col = c + 1;
      end
   endfunction

   // Pixels still needed to complete the current frame, from the idle state.
   function automatic int unsigned pixels_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned n;
      w = active_width();
      h = active_height();
      n = (pred_in_col + 1 >= w) ? 1 : w - pred_in_col;
      if (pred_in_row + 1 < h)
         n += (h - pred_in_row - 1) * w;
      return n;
   endfunction

   task automatic push_item(sor_req_kind_type kind, logic [7:0] px);
      stream_item_t it;
      it.kind  = kind;
      it.pixel = px;
      send_q.push_back(it);
   endtask

   // Register write; only called while the filter is idle.
   task automatic write_register(sor_csr_type idx, logic [7:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width   = value;
         CSR_FRAME_HEIGHT:   cfg_height  = value;
         CSR_EDGE_COLOR:     cfg_edge    = value;
         CSR_FILL_COLOR:     cfg_fill    = value;
         CSR_OUTLINE_ENABLE: cfg_outline = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Wait until every item is sent and every owed pixel has come back.
   task automatic wait_drained();
      while (send_q.size() != 0 || req_if.valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      stream_item_t staged;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            predict_outline(sor_req_kind_type'(req_if.req_type), req_if.pixel_in);

         if (req_if.valid && !req_if.ready) begin
            // Offered item not taken yet; keep it on the bus.
         end else if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (send_q.size() > 0) begin
            staged = send_q.pop_front();
            req_if.valid    <= 1'b1;
            req_if.req_type <= staged.kind;
            req_if.pixel_in <= staged.pixel;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                         : $urandom_range(1, 12);
               gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response monitor and its stall pattern, with one long hold-off while
   // the sender keeps offering items.
   rx_mode_t rx_mode        = RX_STREAM;
   int       rx_mode_left   = 0;
   int       hold_left      = 0;
   bit       long_hold_done = 1'b0;

   always @(posedge clock) begin
      outline_result_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected transfer: pixel_out=%0h frame_last=%0b",
                      rsp_if.pixel_out, rsp_if.frame_last);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_if.pixel_out !== want.pixel) begin
                  $error("pixel_out: expected %0h, actual %0h", want.pixel, rsp_if.pixel_out);
                  mismatch_count++;
               end
               if (rsp_if.frame_last !== want.last) begin
                  $error("frame_last: expected %0b, actual %0b", want.last, rsp_if.frame_last);
                  mismatch_count++;
               end
            end
         end

         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!long_hold_done && send_q.size() > 40) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_if.ready <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               case ($urandom_range(0, 3))
                  0, 1:    rx_mode = RX_STREAM;
                  2:       rx_mode = RX_HALF;
                  default: rx_mode = RX_SPARSE;
               endcase
               rx_mode_left = $urandom_range(8, 64);
               if ($urandom_range(0, 19) == 0)
                  hold_left = $urandom_range(40, 120);
            end else begin
               rx_mode_left--;
            end
            case (rx_mode)
               RX_STREAM: rsp_if.ready <= 1'b1;
               RX_HALF:   rsp_if.ready <= ($urandom_range(0, 1) == 0);
               default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_write_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[silhouette_outline_filter] ERROR");
            $finish;
         end
      end
   end

   // Stimulus: directed frames first, then random phases.
   initial begin
      int          phase;
      int          frames;
      int          density;
      int          stream_items;
      int unsigned rest;
      int unsigned pick;
      logic [7:0]  value;
      bit          at_start;
      bit          big_now;
      bit          big_last;
      bit          partial;
      bit          wide_done;
      bit          tall_done;

      phase        = 0;
      stream_items = 0;
      big_last     = 1'b0;
      wide_done    = 1'b0;
      tall_done    = 1'b0;

      clock           = 1'b0;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = CSR_FRAME_WIDTH;
      csr_wdata       = 8'd0;
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_PIXEL;
      req_if.pixel_in = 8'd0;
      rsp_if.ready    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 3x3 frame whose zero center has four set neighbors and turns to fill.
      // A flush before the frame ends is ignored, a pixel after the end acts
      // as a flush, and a flush after the drain yields nothing.
      write_register(CSR_FRAME_WIDTH, 8'd3);
      write_register(CSR_FRAME_HEIGHT, 8'd3);
      write_register(CSR_EDGE_COLOR, 8'hA5);
      write_register(CSR_FILL_COLOR, 8'h5A);
      write_register(CSR_OUTLINE_ENABLE, 1'b1);
      push_item(REQ_FLUSH, 8'h00);
      push_item(REQ_PIXEL, 8'h00);
      push_item(REQ_PIXEL, 8'hFF);
      push_item(REQ_PIXEL, 8'h00);
      push_item(REQ_PIXEL, 8'h01);
      push_item(REQ_PIXEL, 8'h00);
      push_item(REQ_PIXEL, 8'h80);
      push_item(REQ_PIXEL, 8'h00);
      push_item(REQ_PIXEL, 8'h40);
      push_item(REQ_PIXEL, 8'h00);
      push_item(REQ_FLUSH, 8'h00);
      push_item(REQ_PIXEL, 8'hFF);
      push_item(REQ_FLUSH, 8'h00);
      push_item(REQ_FLUSH, 8'h00);
      wait_drained();

      // Zero width and height act as a single pixel; outline off passes bytes.
      write_register(CSR_FRAME_WIDTH, 8'd0);
      write_register(CSR_FRAME_HEIGHT, 8'd0);
      write_register(CSR_OUTLINE_ENABLE, 1'b0);
      push_item(REQ_PIXEL, 8'hFF);
      push_item(REQ_PIXEL, 8'h00);
      push_item(REQ_FLUSH, 8'h00);
      wait_drained();

      // Solid 3x3 frame with extreme colors: fill in the middle, edge around.
      write_register(CSR_FRAME_WIDTH, 8'd3);
      write_register(CSR_FRAME_HEIGHT, 8'd3);
      write_register(CSR_EDGE_COLOR, 8'h00);
      write_register(CSR_FILL_COLOR, 8'hFF);
      write_register(CSR_OUTLINE_ENABLE, 1'b1);
      repeat (9) push_item(REQ_PIXEL, 8'hFF);
      repeat (3) push_item(REQ_FLUSH, 8'h00);
      wait_drained();

      // Random phases: mostly whole frames with random content, some cut
      // short so the next settings land in the middle of a frame.
      while (stream_items < ITEM_TARGET) begin
         phase++;
         at_start = (pred_in_col == 0 && pred_in_row == 0);
         big_now  = 1'b0;

         if (at_start && phase >= 3 && !wide_done) begin
            write_register(CSR_FRAME_WIDTH, 8'd255);
            write_register(CSR_FRAME_HEIGHT, 8'd1);
            wide_done = 1'b1;
            big_now   = 1'b1;
         end else if (at_start && phase >= 9 && !tall_done) begin
            write_register(CSR_FRAME_WIDTH, 8'd1);
            write_register(CSR_FRAME_HEIGHT, 8'd255);
            tall_done = 1'b1;
            big_now   = 1'b1;
         end else if (big_last || !at_start || $urandom_range(0, 1) == 0) begin
            // Width may only shrink in the middle of a frame.
            if (big_last || $urandom_range(0, 99) < 40) begin
               pick = $urandom_range(0, 99);
               value = (pick < 70) ? $urandom_range(1, 10) :
                       (pick < 95) ? $urandom_range(11, 40) : 0;
               if (at_start || ((value == 0) ? 1 : value) <= active_width())
                  write_register(CSR_FRAME_WIDTH, value);
            end
            if (big_last || $urandom_range(0, 99) < (at_start ? 40 : 60)) begin
               pick = $urandom_range(0, 99);
               value = (pick < 75) ? $urandom_range(1, 8) :
                       (pick < 95) ? $urandom_range(9, 24) : 0;
               write_register(CSR_FRAME_HEIGHT, value);
            end
            if ($urandom_range(0, 99) < 40) begin
               value = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                   : $urandom_range(0, 255);
               write_register(CSR_EDGE_COLOR, value);
            end
            if ($urandom_range(0, 99) < 40) begin
               value = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                   : $urandom_range(0, 255);
               write_register(CSR_FILL_COLOR, value);
            end
            if ($urandom_range(0, 99) < 30)
               write_register(CSR_OUTLINE_ENABLE, ($urandom_range(0, 4) != 0));
         end
         big_last = big_now;

         frames = big_now ? 1 : $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            rest = (f == 0) ? pixels_to_frame_end() : active_width() * active_height();
            partial = !big_now && (f == frames - 1) && (rest > 1) &&
                      ($urandom_range(0, 99) < 15);
            if (partial)
               rest = $urandom_range(1, rest - 1);

            case ($urandom_range(0, 3))
               0:       density = 30;
               1:       density = 70;
               2:       density = 90;
               default: density = 100;
            endcase

            // Frame pixels, with the odd stray flush ahead of one.
            for (int unsigned i = 0; i < rest; i++) begin
               if ($urandom_range(0, 99) < 4)
                  push_item(REQ_FLUSH, $urandom_range(0, 255));
               value = ($urandom_range(0, 99) < density) ? $urandom_range(1, 255) : 8'h00;
               push_item(REQ_PIXEL, value);
               stream_items++;
            end

            // Drain the last row with flushes and ignored pixels.
            if (!partial) begin
               for (int unsigned i = 0; i < active_width(); i++) begin
                  if ($urandom_range(0, 1))
                     push_item(REQ_FLUSH, $urandom_range(0, 255));
                  else
                     push_item(REQ_PIXEL, $urandom_range(0, 255));
                  stream_items++;
               end
               if ($urandom_range(0, 4) == 0)
                  repeat ($urandom_range(1, 2)) push_item(REQ_FLUSH, $urandom_range(0, 255));
            end
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[silhouette_outline_filter] OK");
      else
         $display("[silhouette_outline_filter] ERROR");
      $finish;
   end

endmodule

// File: silhouette_outline_filter.f
hw/rtl/sor_pkg.sv
hw/rtl/sor_req_if.sv
hw/rtl/sor_rsp_if.sv
hw/rtl/sor_cell.sv
hw/rtl/sor_line_chain.sv
hw/rtl/silhouette_outline_filter.sv
dv/silhouette_outline_filter_tb.sv
